/* design/wrs_pkg.sv */
// Shared types and constants of the warp register scoreboard.
`timescale 1ns / 1ps
`default_nettype none

package wrs_pkg;

    localparam int REG_W     = 8;
    localparam int WARP_W    = 6;
    localparam int DST_MAX   = 4;
    localparam int SRC_SLOTS = 4;
    localparam int OPND_NUM  = SRC_SLOTS + 3;

    localparam logic [1:0] OP_RESERVE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_CHECK   = 2'd2;

    typedef logic [REG_W-1:0] wrs_regnum_t;

    typedef struct packed {
        logic                          do_reserve;
        logic                          do_release;
        logic                          do_check;
        logic                          warp_ok;
        logic                          long_load;
        logic [WARP_W-1:0]             warp;
        wrs_regnum_t [DST_MAX-1:0]     dst;
        logic [DST_MAX-1:0]            dst_ok;
        wrs_regnum_t [OPND_NUM-1:0]    opnd;
        logic [OPND_NUM-1:0]           opnd_ok;
        wrs_regnum_t                   query;
        logic                          query_ok;
    } wrs_item_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } wrs_bk_state_t;

endpackage

`default_nettype wire

/* design/warp_register_scoreboard_unit.sv */
// Top level of the warp register scoreboard.
`timescale 1ns / 1ps
`default_nettype none

// Each warp keeps a pending mark and a long-op mark for every register. A word is
// decoded on entry and held in a two-entry queue; the back end then handles a word
// in a read step, which reads the warp's two rows from the row memories, and then an
// update step, which updates, writes back and registers the result word; it takes no
// new word until the update step is done. The result register lets the next word be
// read while a result still waits. Reset clears a flip-flop valid bit per warp row at
// once, so there is no clearing pass.

module warp_register_scoreboard_unit #(
    parameter int NUM_WARPS = 64,
    parameter int NUM_REGS  = 256,
    parameter int DST_SLOTS = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  op,
    input  wire logic [5:0]  warp,
    input  wire logic [31:0] dst_regs,
    input  wire logic [31:0] src_regs,
    input  wire logic [7:0]  pred_reg,
    input  wire logic [7:0]  addr_reg_a,
    input  wire logic [7:0]  addr_reg_b,
    input  wire logic        long_load,
    input  wire logic [7:0]  query_reg,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             collision,
    output logic             long_op,
    output logic             pending_writes,
    output logic             double_reserve
);
    import wrs_pkg::*;

    logic      push;
    logic      q_full;
    logic      q_pop;
    logic      q_not_empty;
    wrs_item_t push_item;
    wrs_item_t q_head;

    wrs_front #(
        .NUM_WARPS (NUM_WARPS),
        .NUM_REGS  (NUM_REGS),
        .DST_SLOTS (DST_SLOTS)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .warp       (warp),
        .dst_regs   (dst_regs),
        .src_regs   (src_regs),
        .pred_reg   (pred_reg),
        .addr_reg_a (addr_reg_a),
        .addr_reg_b (addr_reg_b),
        .long_load  (long_load),
        .query_reg  (query_reg),
        .q_full     (q_full),
        .push       (push),
        .item       (push_item)
    );

    wrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    wrs_back #(
        .NUM_WARPS (NUM_WARPS),
        .NUM_REGS  (NUM_REGS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .collision      (collision),
        .long_op        (long_op),
        .pending_writes (pending_writes),
        .double_reserve (double_reserve)
    );

endmodule

`default_nettype wire

/* design/wrs_front.sv */
// Front end: accepts input words and decodes them into queue entries.
`timescale 1ns / 1ps
`default_nettype none

module wrs_front #(
    parameter int NUM_WARPS = 64,
    parameter int NUM_REGS  = 256,
    parameter int DST_SLOTS = 4
) (
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             op,
    input  wire logic [5:0]             warp,
    input  wire logic [31:0]            dst_regs,
    input  wire logic [31:0]            src_regs,
    input  wire logic [7:0]             pred_reg,
    input  wire logic [7:0]             addr_reg_a,
    input  wire logic [7:0]             addr_reg_b,
    input  wire logic                   long_load,
    input  wire logic [7:0]             query_reg,
    input  wire logic                   q_full,
    output logic                        push,
    output wrs_pkg::wrs_item_t          item
);
    import wrs_pkg::*;

    function automatic logic reg_ok(input wrs_regnum_t r);
        reg_ok = (r != '0) && ({1'b0, r} < 9'(NUM_REGS));
    endfunction

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        item            = '0;
        item.warp       = warp;
        item.warp_ok    = {3'b000, warp} < 9'(NUM_WARPS);
        item.long_load  = long_load;
        unique case (op)
            OP_RESERVE: item.do_reserve = 1'b1;
            OP_RELEASE: item.do_release = 1'b1;
            OP_CHECK:   item.do_check   = 1'b1;
            default:    item.do_check   = 1'b0;
        endcase
        for (int k = 0; k < DST_MAX; k++)
        begin
            item.dst[k]    = dst_regs[REG_W*k +: REG_W];
            item.dst_ok[k] = (k < DST_SLOTS) && reg_ok(dst_regs[REG_W*k +: REG_W]);
        end
        for (int k = 0; k < SRC_SLOTS; k++)
        begin
            item.opnd[k] = src_regs[REG_W*k +: REG_W];
        end
        item.opnd[SRC_SLOTS]     = pred_reg;
        item.opnd[SRC_SLOTS + 1] = addr_reg_a;
        item.opnd[SRC_SLOTS + 2] = addr_reg_b;
        for (int k = 0; k < OPND_NUM; k++)
        begin
            item.opnd_ok[k] = reg_ok(item.opnd[k]);
        end
        item.query    = query_reg;
        item.query_ok = reg_ok(query_reg);
    end

endmodule

`default_nettype wire

/* design/wrs_queue.sv */
// Two-entry queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module wrs_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire wrs_pkg::wrs_item_t     push_item,
    output logic                        full,
    input  wire logic                   pop,
    output logic                        not_empty,
    output wrs_pkg::wrs_item_t          head
);
    import wrs_pkg::*;

    wrs_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* design/wrs_back.sv */
// Back end: reads a warp's rows, updates them and registers the result word.
`timescale 1ns / 1ps
`default_nettype none

module wrs_back #(
    parameter int NUM_WARPS = 64,
    parameter int NUM_REGS  = 256
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_not_empty,
    input  wire wrs_pkg::wrs_item_t     q_head,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        collision,
    output logic                        long_op,
    output logic                        pending_writes,
    output logic                        double_reserve
);
    import wrs_pkg::*;

    localparam int WIDX = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1;
    localparam int RIDX = $clog2(NUM_REGS);

    logic [NUM_REGS-1:0]  pend_mem [NUM_WARPS];
    logic [NUM_REGS-1:0]  long_mem [NUM_WARPS];
    logic [NUM_REGS-1:0]  pend_rd_reg;
    logic [NUM_REGS-1:0]  long_rd_reg;
    logic [NUM_WARPS-1:0] row_valid_reg;
    logic                 hit_reg;
    wrs_item_t            item_reg;
    wrs_bk_state_t        state_reg;
    wrs_bk_state_t        state_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 collision_reg;
    logic                 long_op_reg;
    logic                 pending_reg;
    logic                 double_reg;

    logic [8:0]           head_warp_ext;
    logic [WIDX-1:0]      head_idx;
    logic [8:0]           item_warp_ext;
    logic [WIDX-1:0]      item_idx;
    logic                 fire;
    logic                 wr_en;
    logic [NUM_REGS-1:0]  prow;
    logic [NUM_REGS-1:0]  lrow;
    logic [NUM_REGS-1:0]  dst_mask;
    logic [NUM_REGS-1:0]  new_p;
    logic [NUM_REGS-1:0]  new_l;
    logic                 coll_c;
    logic                 lop_c;
    logic                 dbl_c;
    logic                 pend_c;

    assign head_warp_ext = {3'b000, q_head.warp};
    assign head_idx      = head_warp_ext[WIDX-1:0];
    assign item_warp_ext = {3'b000, item_reg.warp};
    assign item_idx      = item_warp_ext[WIDX-1:0];

    assign out_valid      = out_valid_reg;
    assign collision      = collision_reg;
    assign long_op        = long_op_reg;
    assign pending_writes = pending_reg;
    assign double_reserve = double_reg;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        fire       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    pop        = 1'b1;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    fire       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        out_valid_next = fire || (out_valid_reg && out_stall);
    end

    always_comb
    begin
        prow     = hit_reg ? pend_rd_reg : '0;
        lrow     = hit_reg ? long_rd_reg : '0;
        dst_mask = '0;
        dbl_c    = 1'b0;
        coll_c   = 1'b0;
        for (int k = 0; k < DST_MAX; k++)
        begin
            if (item_reg.dst_ok[k])
            begin
                dst_mask[item_reg.dst[k][RIDX-1:0]] = 1'b1;
                if (prow[item_reg.dst[k][RIDX-1:0]])
                begin
                    dbl_c  = 1'b1;
                    coll_c = 1'b1;
                end
                for (int j = 0; j < k; j++)
                begin
                    if (item_reg.dst_ok[j] && (item_reg.dst[j] == item_reg.dst[k]))
                    begin
                        dbl_c = 1'b1;
                    end
                end
            end
        end
        for (int k = 0; k < OPND_NUM; k++)
        begin
            if (item_reg.opnd_ok[k] && prow[item_reg.opnd[k][RIDX-1:0]])
            begin
                coll_c = 1'b1;
            end
        end
        lop_c = item_reg.query_ok && lrow[item_reg.query[RIDX-1:0]];
        new_p = prow;
        new_l = lrow;
        if (item_reg.do_reserve)
        begin
            new_p = prow | dst_mask;
            new_l = item_reg.long_load ? (lrow | dst_mask) : lrow;
        end
        else if (item_reg.do_release)
        begin
            new_p = prow & ~dst_mask;
            new_l = lrow & ~dst_mask;
        end
        pend_c = |new_p;
        wr_en  = fire && item_reg.warp_ok && (item_reg.do_reserve || item_reg.do_release);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (wr_en)
            begin
                row_valid_reg[item_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg    <= q_head;
            hit_reg     <= row_valid_reg[head_idx];
            pend_rd_reg <= pend_mem[head_idx];
            long_rd_reg <= long_mem[head_idx];
        end
        if (wr_en)
        begin
            pend_mem[item_idx] <= new_p;
            long_mem[item_idx] <= new_l;
        end
        if (fire)
        begin
            collision_reg <= item_reg.warp_ok && item_reg.do_check && coll_c;
            long_op_reg   <= item_reg.warp_ok && item_reg.do_check && lop_c;
            double_reg    <= item_reg.warp_ok && item_reg.do_reserve && dbl_c;
            pending_reg   <= item_reg.warp_ok && pend_c;
        end
    end

endmodule

`default_nettype wire
